// ----- sv/vad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_pkg
// shared widths, angle table and control types for the vector angle core
// ----------------------------------------------------------------------------
package vad_pkg;

    // field widths
    localparam int XW = 16;
    localparam int OW = 16;

    // cordic datapath: inputs scaled by 2^24, angle in 2^-20 degree
    localparam int PRESCALE = 24;
    localparam int ACC_BITS = 20;
    localparam int STEPS    = 24;
    localparam int AW       = 43;
    localparam int ZW       = 30;

    // default output fraction bits
    localparam int ANGLE_FRACTION_BITS_DEF = 7;

    typedef logic signed [AW-1:0] t_vec;
    typedef logic signed [ZW-1:0] t_ang;

    // fixed angles in accumulator units
    localparam t_ang ANG_90  = t_ang'(94371840);
    localparam t_ang ANG_180 = t_ang'(188743680);

    // atan(2^-i) in degrees, scaled by 2^20
    localparam t_ang STEP_ANGLE [STEPS] = '{
        t_ang'(47185920), t_ang'(27855475), t_ang'(14718068), t_ang'(7471121),
        t_ang'(3750058),  t_ang'(1876857),  t_ang'(938658),   t_ang'(469357),
        t_ang'(234682),   t_ang'(117342),   t_ang'(58671),    t_ang'(29335),
        t_ang'(14668),    t_ang'(7334),     t_ang'(3667),     t_ang'(1833),
        t_ang'(917),      t_ang'(458),      t_ang'(229),      t_ang'(115),
        t_ang'(57),       t_ang'(29),       t_ang'(14),       t_ang'(7)
    };

    // per-stage control travelling with the data
    typedef struct packed {
        logic vld;
        logic fixed;
    } t_ctl;

endpackage

// ----- sv/vector_angle_degrees_core.sv -----
// registered stages from input accept to result valid: prep, 24 cordic, round
// throughput: one item per cycle while not stalled; the whole pipeline advances together
// the pipeline holds whenever the output register is full and not taken
// reset (synchronous, active low) clears all stage valid bits; data is not reset
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_angle_degrees_core
// atan2(x, y) in degrees from the +y axis, by a pipelined vectoring cordic
// ----------------------------------------------------------------------------
module vector_angle_degrees_core #(
    parameter int ANGLE_FRACTION_BITS = vad_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [vad_pkg::XW-1:0] i_x_component,
    input  logic signed [vad_pkg::XW-1:0] i_y_component,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [vad_pkg::OW-1:0] o_angle
);

    logic                   w_en;
    logic [vad_pkg::OW-1:0] w_angle;
    vad_pkg::t_ctl          w_ctl [vad_pkg::STEPS+1];
    vad_pkg::t_vec          w_a   [vad_pkg::STEPS+1];
    vad_pkg::t_vec          w_b   [vad_pkg::STEPS+1];
    vad_pkg::t_ang          w_z   [vad_pkg::STEPS+1];

    // pipeline advances unless a finished item is stuck at the output
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // input stage
    vad_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_x     (i_x_component),
        .i_y     (i_y_component),
        .o_ctl   (w_ctl[0]),
        .o_a     (w_a[0]),
        .o_b     (w_b[0]),
        .o_z     (w_z[0])
    );

    // cordic micro-rotation chain
    for (genvar k = 0; k < vad_pkg::STEPS; k++) begin : g_stage
        vad_stage #(
            .IDX (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[k]),
            .i_a     (w_a[k]),
            .i_b     (w_b[k]),
            .i_z     (w_z[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_a     (w_a[k+1]),
            .o_b     (w_b[k+1]),
            .o_z     (w_z[k+1])
        );
    end

    // output stage
    vad_round #(
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl[vad_pkg::STEPS]),
        .i_z     (w_z[vad_pkg::STEPS]),
        .o_valid (o_valid),
        .o_angle (w_angle)
    );

    assign o_angle = w_angle;

`ifndef SYNTHESIS
    localparam int LIMIT = 180 << ANGLE_FRACTION_BITS;

    // a stalled pipeline keeps its valid bits where they are
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_ctl[0].vld) && $stable(w_ctl[vad_pkg::STEPS].vld))
        else $error("pipeline valid moved during stall");

    // an accepted item shows up in the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> w_ctl[0].vld)
        else $error("accepted item lost at input stage");

    // a zero vector is a fixed item with angle zero
    a_zero_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_x_component == '0 && i_y_component == '0
        |=> w_ctl[0].fixed && w_z[0] == '0)
        else $error("zero vector not folded to a fixed zero angle");

    // fixed items pass their angle through a rotation stage untouched
    a_fixed_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && w_ctl[0].fixed |=> w_z[1] == $past(w_z[0]))
        else $error("fixed angle changed by a rotation stage");

    // results stay inside +-180 degrees when that fits the output field
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ANGLE_FRACTION_BITS > 7
            || (int'(o_angle) <= LIMIT && int'(o_angle) >= -LIMIT))
        else $error("angle outside +-180 degrees");
`endif

endmodule

// ----- sv/vad_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_prep
// input stage: special cases, half-plane fold and prescale into the cordic
// ----------------------------------------------------------------------------
module vad_prep (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [vad_pkg::XW-1:0] i_x,
    input  logic signed [vad_pkg::XW-1:0] i_y,
    output vad_pkg::t_ctl               o_ctl,
    output vad_pkg::t_vec               o_a,
    output vad_pkg::t_vec               o_b,
    output vad_pkg::t_ang               o_z
);

    localparam int PADW = vad_pkg::AW - vad_pkg::XW - 1 - vad_pkg::PRESCALE;

    logic signed [vad_pkg::XW:0] w_xe;
    logic signed [vad_pkg::XW:0] w_ye;
    logic signed [vad_pkg::XW:0] w_re;
    logic signed [vad_pkg::XW:0] w_im;
    logic                        n_fixed;
    vad_pkg::t_ang               n_z;
    vad_pkg::t_ang               r_z;
    vad_pkg::t_vec               r_a;
    vad_pkg::t_vec               r_b;
    vad_pkg::t_ctl               r_ctl;

    assign w_xe = {i_x[vad_pkg::XW-1], i_x};
    assign w_ye = {i_y[vad_pkg::XW-1], i_y};

    // classify and fold the lower half plane onto the upper one
    always_comb begin
        w_re    = w_ye;
        w_im    = w_xe;
        n_fixed = 1'b0;
        n_z     = '0;
        if (i_x == '0) begin
            n_fixed = 1'b1;
            n_z     = i_y[vad_pkg::XW-1] ? vad_pkg::ANG_180 : '0;
        end else if (i_y == '0) begin
            n_fixed = 1'b1;
            n_z     = i_x[vad_pkg::XW-1] ? -vad_pkg::ANG_90 : vad_pkg::ANG_90;
        end else if (i_y[vad_pkg::XW-1]) begin
            w_re = -w_ye;
            w_im = -w_xe;
            n_z  = i_x[vad_pkg::XW-1] ? -vad_pkg::ANG_180 : vad_pkg::ANG_180;
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl.vld   <= i_valid;
            r_ctl.fixed <= n_fixed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= {{PADW{w_re[vad_pkg::XW]}}, w_re, {vad_pkg::PRESCALE{1'b0}}};
            r_b <= {{PADW{w_im[vad_pkg::XW]}}, w_im, {vad_pkg::PRESCALE{1'b0}}};
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_z   = r_z;

endmodule

// ----- sv/vad_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_stage
// one vectoring micro-rotation of the cordic, registered
// ----------------------------------------------------------------------------
module vad_stage #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  vad_pkg::t_ctl i_ctl,
    input  vad_pkg::t_vec i_a,
    input  vad_pkg::t_vec i_b,
    input  vad_pkg::t_ang i_z,
    output vad_pkg::t_ctl o_ctl,
    output vad_pkg::t_vec o_a,
    output vad_pkg::t_vec o_b,
    output vad_pkg::t_ang o_z
);

    localparam vad_pkg::t_ang ANG = vad_pkg::STEP_ANGLE[IDX];

    vad_pkg::t_vec w_da;
    vad_pkg::t_vec w_db;
    vad_pkg::t_vec n_a;
    vad_pkg::t_vec n_b;
    vad_pkg::t_ang n_z;
    vad_pkg::t_vec r_a;
    vad_pkg::t_vec r_b;
    vad_pkg::t_ang r_z;
    vad_pkg::t_ctl r_ctl;

    // floor shifts
    assign w_da = i_b >>> IDX;
    assign w_db = i_a >>> IDX;

    // rotate towards b = 0; fixed items pass their angle through
    always_comb begin
        if (!i_b[vad_pkg::AW-1]) begin
            n_a = i_a + w_da;
            n_b = i_b - w_db;
            n_z = i_z + ANG;
        end else begin
            n_a = i_a - w_da;
            n_b = i_b + w_db;
            n_z = i_z - ANG;
        end
        if (i_ctl.fixed) begin
            n_z = i_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_z   = r_z;

endmodule

// ----- sv/vad_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_round
// output stage: round to the output lsb, clamp to +-180 degrees
// ----------------------------------------------------------------------------
module vad_round #(
    parameter int ANGLE_FRACTION_BITS = vad_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  vad_pkg::t_ctl         i_ctl,
    input  vad_pkg::t_ang         i_z,
    output logic                  o_valid,
    output logic [vad_pkg::OW-1:0] o_angle
);

    localparam int SH = vad_pkg::ACC_BITS - ANGLE_FRACTION_BITS;
    localparam vad_pkg::t_ang HALF  = vad_pkg::t_ang'(1) <<< (SH - 1);
    localparam vad_pkg::t_ang LIMIT = vad_pkg::t_ang'(180) <<< ANGLE_FRACTION_BITS;

    vad_pkg::t_ang          w_sum;
    vad_pkg::t_ang          w_res;
    vad_pkg::t_ang          n_clamp;
    logic                   r_vld;
    logic [vad_pkg::OW-1:0] r_angle;

    // round half up, then floor shift
    assign w_sum = i_z + HALF;
    assign w_res = w_sum >>> SH;

    // clamp
    always_comb begin
        n_clamp = w_res;
        if (w_res > LIMIT) begin
            n_clamp = LIMIT;
        end else if (w_res < -LIMIT) begin
            n_clamp = -LIMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_clamp[vad_pkg::OW-1:0];
        end
    end

    assign o_valid = r_vld;
    assign o_angle = r_angle;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for vector_angle_degrees_core
// drives signed stick vectors through valid/ready, predicts the atan2 angle
// in 1/128 degree with its own vectoring cordic, and checks every result
// in order under throttled, back-to-back and long back-pressure traffic
// ----------------------------------------------------------------------------

// in-order store of predicted angles and the checks against the block
class angle_scoreboard;

    localparam int ACC_FRAC   = 20;
    localparam int PRE_SHIFT  = 24;
    localparam int ROTATIONS  = 24;

    typedef struct {
        logic signed [vad_pkg::XW-1:0] x;
        logic signed [vad_pkg::XW-1:0] y;
        logic signed [vad_pkg::OW-1:0] angle;
    } pending_angle_t;

    pending_angle_t pending_angles[$];
    int             frac_bits;
    int             vectors_noted;
    int             angles_compared;
    int             mismatches;

    function new(int frac);
        frac_bits       = frac;
        vectors_noted   = 0;
        angles_compared = 0;
        mismatches      = 0;
    endfunction

    // atan(2^-i) in degrees, scaled by 2^20
    function longint micro_angle(int i);
        case (i)
            0: return 47185920;   1: return 27855475;   2: return 14718068;
            3: return 7471121;    4: return 3750058;    5: return 1876857;
            6: return 938658;     7: return 469357;     8: return 234682;
            9: return 117342;     10: return 58671;     11: return 29335;
            12: return 14668;     13: return 7334;      14: return 3667;
            15: return 1833;      16: return 917;       17: return 458;
            18: return 229;       19: return 115;       20: return 57;
            21: return 29;        22: return 14;
            default: return 7;
        endcase
    endfunction

    // rotate (re, im) onto the real axis, re >= 0, angle in 2^-20 degree
    function longint turn_to_axis(longint im, longint re);
        longint a;
        longint b;
        longint z;
        longint da;
        longint db;
        a = re <<< PRE_SHIFT;
        b = im <<< PRE_SHIFT;
        z = 0;
        for (int i = 0; i < ROTATIONS; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0) begin
                a = a + da;
                b = b - db;
                z = z + micro_angle(i);
            end else begin
                a = a - da;
                b = b + db;
                z = z - micro_angle(i);
            end
        end
        return z;
    endfunction

    // angle from +y toward +x, rounded to the output lsb and clamped
    function logic signed [vad_pkg::OW-1:0] predict_angle(
        logic signed [vad_pkg::XW-1:0] x, logic signed [vad_pkg::XW-1:0] y);
        longint xs;
        longint ys;
        longint unit;
        longint total;
        longint res;
        longint lim;
        xs   = longint'(x);
        ys   = longint'(y);
        unit = longint'(1) <<< ACC_FRAC;
        lim  = longint'(180) <<< frac_bits;
        if (xs == 0) begin
            total = (ys >= 0) ? 0 : 180 * unit;
        end else if (ys == 0) begin
            total = (xs > 0) ? 90 * unit : -90 * unit;
        end else if (ys > 0) begin
            total = turn_to_axis(xs, ys);
        end else begin
            // lower half plane: turn by half a revolution first
            total = ((xs < 0) ? -180 * unit : 180 * unit) + turn_to_axis(-xs, -ys);
        end
        res = (total + (longint'(1) <<< (ACC_FRAC - frac_bits - 1)))
              >>> (ACC_FRAC - frac_bits);
        if (res > lim) res = lim;
        if (res < -lim) res = -lim;
        return res[vad_pkg::OW-1:0];
    endfunction

    // accepted input item: queue its predicted angle
    function void note_vector(logic signed [vad_pkg::XW-1:0] x,
                              logic signed [vad_pkg::XW-1:0] y);
        pending_angle_t p;
        p.x     = x;
        p.y     = y;
        p.angle = predict_angle(x, y);
        pending_angles.push_back(p);
        vectors_noted++;
    endfunction

    // accepted result item: compare with the oldest prediction
    function void check_angle(logic signed [vad_pkg::OW-1:0] angle);
        pending_angle_t p;
        if (pending_angles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("angle %0d arrived with no vector outstanding", angle);
            return;
        end
        p = pending_angles.pop_front();
        angles_compared++;
        if (angle !== p.angle) begin
            mismatches++;
            if (mismatches <= 10)
                $display("angle mismatch for x=%0d y=%0d: expected %0d, got %0d",
                         p.x, p.y, p.angle, angle);
        end
    endfunction

    function int outstanding();
        return pending_angles.size();
    endfunction

endclass

module testbench;

    localparam int ANGLE_FRAC  = 7;
    localparam int CLK_HALF    = 5;
    localparam int TAIL_CYCLES = 32;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic signed [vad_pkg::XW-1:0] i_x_component = '0;
    logic signed [vad_pkg::XW-1:0] i_y_component = '0;
    logic o_ready;
    logic o_valid;
    logic signed [vad_pkg::OW-1:0] o_angle;

    angle_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_granted = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    vector_angle_degrees_core #(
        .ANGLE_FRACTION_BITS(ANGLE_FRAC)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_x_component (i_x_component),
        .i_y_component (i_y_component),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_angle       (o_angle)
    );

    // clock
    always #CLK_HALF i_clk = ~i_clk;

    // handshake monitor: note accepted vectors, check accepted angles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_vector(i_x_component, i_y_component);
            if (o_valid && i_ready)
                sb.check_angle(o_angle);
        end
    end

    // result side: random stalls, plus long hold-offs on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (holds_granted != hold_requests) begin
                holds_granted++;
                hold_left = HOLD_CYCLES - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        wait (i_rst_n);
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // offer one vector, idling first at random, and wait until it is taken
    task automatic send_vector(input int x, input int y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_x_component <= 16'(x);
        i_y_component <= 16'(y);
        do @(posedge i_clk); while (!o_ready);
    endtask

    // stop offering and wait until every predicted angle has come back
    task automatic drain_angles();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    function automatic logic signed [15:0] corner_value();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh8001;
            2: return 16'shFFFF;
            3: return 16'sh0000;
            4: return 16'sh0001;
            default: return 16'sh7FFF;
        endcase
    endfunction

    // random vector, biased toward axes, corners and the +-180 seam
    task automatic pick_vector(output logic signed [15:0] x,
                               output logic signed [15:0] y);
        int mode;
        mode = $urandom_range(9);
        x = 16'($urandom);
        y = 16'($urandom);
        case (mode)
            5: begin
                x = 16'($signed($urandom_range(16)) - 8);
                y = 16'($signed($urandom_range(16)) - 8);
            end
            6: begin
                if ($urandom_range(1)) x = '0;
                else y = '0;
            end
            7: begin
                x = corner_value();
                y = corner_value();
            end
            8: begin
                // one component dwarfs the other
                if ($urandom_range(1)) x = 16'($signed($urandom_range(6)) - 3);
                else y = 16'($signed($urandom_range(6)) - 3);
            end
            9: begin
                // just either side of straight down
                x = 16'($signed($urandom_range(64)) - 32);
                y = 16'(-$signed($urandom_range(32768, 1)));
            end
            default: ;
        endcase
    endtask

    task automatic send_random(input int count);
        logic signed [15:0] x;
        logic signed [15:0] y;
        repeat (count) begin
            pick_vector(x, y);
            send_vector(x, y);
        end
    endtask

    // stimulus
    initial begin
        sb = new(ANGLE_FRAC);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: origin, axes, corners, the seam at +-180, bit patterns
        send_vector(0, 0);            send_vector(0, 100);
        send_vector(0, 32767);        send_vector(0, -100);
        send_vector(0, -32768);       send_vector(100, 0);
        send_vector(32767, 0);        send_vector(-100, 0);
        send_vector(-32768, 0);       send_vector(1, 1);
        send_vector(1, -1);           send_vector(-1, -1);
        send_vector(-1, 1);           send_vector(32767, 32767);
        send_vector(-32768, -32768);  send_vector(-32768, 32767);
        send_vector(32767, -32768);   send_vector(1, -32768);
        send_vector(-1, -32768);      send_vector(1, 32767);
        send_vector(-1, 32767);       send_vector(16'hAAAA, 16'h5555);
        send_vector(16'h5555, 16'hAAAA);
        drain_angles();

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 14;
        recv_idle_pct <= 85;
        send_random(260);
        drain_angles();

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 85;
        recv_idle_pct <= 14;
        send_random(260);
        drain_angles();

        // back to back, then a long receiver hold-off to fill the pipeline
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        send_random(140);
        hold_requests <= hold_requests + 1;
        send_random(80);
        send_random(60);
        drain_angles();

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d vectors sent through directed, throttled, back-to-back and held phases",
                 sb.vectors_noted);
        $display("%0d angles compared, %0d mismatches, %0d left outstanding",
                 sb.angles_compared, sb.mismatches, sb.outstanding());
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- vector_angle_degrees_core.f -----
sv/vad_pkg.sv
sv/vad_prep.sv
sv/vad_stage.sv
sv/vad_round.sv
sv/vector_angle_degrees_core.sv
test/testbench.sv
